[rtl/rfpd_pkg.sv]
`default_nettype none

package rfpd_pkg;

  // parameter defaults
  localparam int FRAC_BITS_DEF = 16;
  localparam int VEL_WIDTH_DEF = 48;

  // fixed field widths
  localparam int ACCEL_W    = 16;
  localparam int TIME_W     = 32;
  localparam int EMA_W      = 32;
  localparam int PHASE_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_REG_W  = 16;

  // alpha is unsigned Q1.16 (up to 1.0) regardless of FRAC_BITS
  localparam int                    ALPHA_FRAC = 16;
  localparam logic [CFG_DATA_W-1:0] ALPHA_ONE  = 17'd65536;

  // flight phases
  localparam logic [PHASE_W-1:0] PH_IDLE     = 2'd0;
  localparam logic [PHASE_W-1:0] PH_LAUNCHED = 2'd1;
  localparam logic [PHASE_W-1:0] PH_APOGEE   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAUNCH_CNF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FLIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_APOGEE_CNF = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUTE_LEN  = 3'd6;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] RST_ALPHA      = 17'd13107;
  localparam logic [CFG_REG_W-1:0]  RST_BASELINE   = 16'd2048;
  localparam logic [CFG_REG_W-1:0]  RST_THRESHOLD  = 16'd6144;
  localparam logic [CFG_REG_W-1:0]  RST_LAUNCH_CNF = 16'd50;
  localparam logic [CFG_REG_W-1:0]  RST_MIN_FLIGHT = 16'd1000;
  localparam logic [CFG_REG_W-1:0]  RST_APOGEE_CNF = 16'd100;
  localparam logic [CFG_REG_W-1:0]  RST_CHUTE_LEN  = 16'd1000;

endpackage

`default_nettype wire

[rtl/rocket_flight_phase_detector_top.sv]
`default_nettype none
// Flight phase detector: idle -> launched -> apogee, with a timed parachute pulse.
// Input channel (in_valid_i / in_stall_o): one beat is either a sample (cmd_i = 0:
// accel_vertical_i with time_ms_i) or a restart (cmd_i = 1) that clears the flight
// state and the filter. Output channel (out_valid_o / out_stall_i): one result beat
// per input beat, in order: phase, chute level, filtered acceleration, velocity sum
// and the launch / apogee event flags of that item.
// Pipeline: two register stages, stage 1 and the result register; an accepted
// input beat waits in stage 1 until the result register can take it.
// Throughput: one item per cycle while the output is not stalled. The EMA update
// (one multiply, add, saturate) closes in stage 1, the phase machine with its
// velocity sum closes in stage 2.
// A stalled output holds its beat; stage 1 keeps its item and in_stall_o rises
// only when stage 1 is full and cannot move on, so a new beat is still taken
// while a finished result waits.
// Reset clears the filter, flight state and pipeline valids and loads the register
// defaults. Write registers (cfg_we_i) only while no item is in flight.
module rocket_flight_phase_detector_top #(
  parameter int FRAC_BITS = rfpd_pkg::FRAC_BITS_DEF,
  parameter int VEL_WIDTH = rfpd_pkg::VEL_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [rfpd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [rfpd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            cmd_i,
  input  wire logic signed [rfpd_pkg::ACCEL_W-1:0] accel_vertical_i,
  input  wire logic [rfpd_pkg::TIME_W-1:0]     time_ms_i,
  // output channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [rfpd_pkg::PHASE_W-1:0]         phase_o,
  output logic                                 chute_out_o,
  output logic signed [rfpd_pkg::EMA_W-1:0]    filtered_accel_o,
  output logic signed [VEL_WIDTH-1:0]          velocity_sum_o,
  output logic                                 launch_event_o,
  output logic                                 apogee_event_o
);
  import rfpd_pkg::*;

  localparam int XQ_W   = ACCEL_W + FRAC_BITS;
  localparam int DIFF_W = ((XQ_W > EMA_W) ? XQ_W : EMA_W) + 1;
  localparam int PROD_W = DIFF_W + CFG_DATA_W + 1;
  localparam int SUM_W  = DIFF_W + 1;
  localparam int VS_W   = ((VEL_WIDTH > DIFF_W) ? VEL_WIDTH : DIFF_W) + 1;

  localparam logic signed [EMA_W-1:0]     EMA_MAX = {1'b0, {(EMA_W-1){1'b1}}};
  localparam logic signed [EMA_W-1:0]     EMA_MIN = {1'b1, {(EMA_W-1){1'b0}}};
  localparam logic signed [VEL_WIDTH-1:0] VEL_MAX = {1'b0, {(VEL_WIDTH-1){1'b1}}};
  localparam logic signed [VEL_WIDTH-1:0] VEL_MIN = {1'b1, {(VEL_WIDTH-1){1'b0}}};

  // ---------------- configuration registers ----------------
  logic [CFG_DATA_W-1:0]       alpha_q;
  logic signed [CFG_REG_W-1:0] base_q;
  logic [CFG_REG_W-1:0]        thr_q, lconf_q, minfl_q, aconf_q, pulse_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= RST_ALPHA;
      base_q  <= RST_BASELINE;
      thr_q   <= RST_THRESHOLD;
      lconf_q <= RST_LAUNCH_CNF;
      minfl_q <= RST_MIN_FLIGHT;
      aconf_q <= RST_APOGEE_CNF;
      pulse_q <= RST_CHUTE_LEN;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ALPHA:      alpha_q <= cfg_wdata_i;
        CFG_BASELINE:   base_q  <= cfg_wdata_i[CFG_REG_W-1:0];
        CFG_THRESHOLD:  thr_q   <= cfg_wdata_i[CFG_REG_W-1:0];
        CFG_LAUNCH_CNF: lconf_q <= cfg_wdata_i[CFG_REG_W-1:0];
        CFG_MIN_FLIGHT: minfl_q <= cfg_wdata_i[CFG_REG_W-1:0];
        CFG_APOGEE_CNF: aconf_q <= cfg_wdata_i[CFG_REG_W-1:0];
        CFG_CHUTE_LEN:  pulse_q <= cfg_wdata_i[CFG_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  logic s1_valid_q, out_valid_q;
  logic in_accept, s2_load;

  assign s2_load    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s2_load;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept)   s1_valid_q <= 1'b1;
      else if (s2_load) s1_valid_q <= 1'b0;
      if (s2_load)     out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // ---------------- stage 1: EMA ----------------
  logic signed [EMA_W-1:0]  ema_q, ema_d;
  logic                     seeded_q;
  logic signed [XQ_W-1:0]   xq;
  logic signed [DIFF_W-1:0] diff, step;
  logic signed [17:0]       alpha_eff;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  ema_raw;

  assign xq        = $signed({accel_vertical_i, {FRAC_BITS{1'b0}}});
  assign diff      = DIFF_W'(xq) - DIFF_W'(ema_q);
  assign alpha_eff = (alpha_q > ALPHA_ONE) ? $signed({1'b0, ALPHA_ONE})
                                           : $signed({1'b0, alpha_q});
  assign prod      = PROD_W'(diff) * PROD_W'(alpha_eff);
  // arithmetic shift rounds toward minus infinity
  assign step      = DIFF_W'(prod >>> ALPHA_FRAC);
  assign ema_raw   = seeded_q ? (SUM_W'(ema_q) + SUM_W'(step)) : SUM_W'(xq);

  always_comb begin
    if (cmd_i) begin
      ema_d = '0;
    end else if (ema_raw > SUM_W'(EMA_MAX)) begin
      ema_d = EMA_MAX;
    end else if (ema_raw < SUM_W'(EMA_MIN)) begin
      ema_d = EMA_MIN;
    end else begin
      ema_d = EMA_W'(ema_raw);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ema_q    <= '0;
      seeded_q <= 1'b0;
    end else if (in_accept) begin
      ema_q    <= ema_d;
      seeded_q <= !cmd_i;
    end
  end

  logic                    s1_cmd_q;
  logic [TIME_W-1:0]       s1_time_q;
  logic signed [EMA_W-1:0] s1_ema_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cmd_q  <= cmd_i;
      s1_time_q <= time_ms_i;
      s1_ema_q  <= ema_d;
    end
  end

  // ---------------- stage 2: phase machine ----------------
  logic [PHASE_W-1:0]          phase_q, phase_d;
  logic signed [VEL_WIDTH-1:0] vel_q, vel_d, vel_new;
  logic                        lpend_q, lpend_d, apend_q, apend_d;
  logic [TIME_W-1:0]           lseen_q, lseen_d, aseen_q, aseen_d;
  logic [TIME_W-1:0]           fbegin_q, fbegin_d, off_q, off_d;
  logic                        chute_fired_q, chute_fired_d;
  logic                        chute_level_q, chute_level_d;
  logic                        ev_launch, ev_apogee;

  logic signed [XQ_W-1:0]   base_sh;
  logic signed [XQ_W:0]     thr_sh;
  logic signed [DIFF_W-1:0] excess;
  logic                     excess_gt, vel_nonpos;
  logic signed [VS_W-1:0]   vsum;
  logic [TIME_W-1:0]        lseen_eff, aseen_eff;
  logic [TIME_W-1:0]        l_elapsed, a_elapsed, f_elapsed, off_diff;

  assign base_sh   = $signed({base_q, {FRAC_BITS{1'b0}}});
  assign thr_sh    = $signed({1'b0, thr_q, {FRAC_BITS{1'b0}}});
  assign excess    = DIFF_W'(s1_ema_q) - DIFF_W'(base_sh);
  assign excess_gt = excess > DIFF_W'(thr_sh);

  assign vsum = VS_W'(vel_q) + VS_W'(excess);
  always_comb begin
    if (vsum > VS_W'(VEL_MAX)) begin
      vel_new = VEL_MAX;
    end else if (vsum < VS_W'(VEL_MIN)) begin
      vel_new = VEL_MIN;
    end else begin
      vel_new = VEL_WIDTH'(vsum);
    end
  end
  assign vel_nonpos = vel_new[VEL_WIDTH-1] || (vel_new == '0);

  // a mark set on this item gives zero elapsed time
  assign lseen_eff = lpend_q ? lseen_q : s1_time_q;
  assign aseen_eff = apend_q ? aseen_q : s1_time_q;
  assign l_elapsed = s1_time_q - lseen_eff;
  assign a_elapsed = s1_time_q - aseen_eff;
  assign f_elapsed = s1_time_q - fbegin_q;
  assign off_diff  = s1_time_q - off_q;

  always_comb begin
    phase_d       = phase_q;
    vel_d         = vel_q;
    lpend_d       = lpend_q;
    lseen_d       = lseen_q;
    apend_d       = apend_q;
    aseen_d       = aseen_q;
    fbegin_d      = fbegin_q;
    chute_fired_d = chute_fired_q;
    off_d         = off_q;
    chute_level_d = chute_level_q;
    ev_launch     = 1'b0;
    ev_apogee     = 1'b0;
    if (s1_cmd_q) begin
      phase_d       = PH_IDLE;
      vel_d         = '0;
      lpend_d       = 1'b0;
      lseen_d       = '0;
      apend_d       = 1'b0;
      aseen_d       = '0;
      fbegin_d      = '0;
      chute_fired_d = 1'b0;
      off_d         = '0;
      chute_level_d = 1'b0;
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          if (excess_gt) begin
            lpend_d = 1'b1;
            lseen_d = lseen_eff;
            if (l_elapsed >= TIME_W'(lconf_q)) begin
              phase_d   = PH_LAUNCHED;
              fbegin_d  = s1_time_q;
              vel_d     = '0;
              ev_launch = 1'b1;
            end
          end else begin
            lpend_d = 1'b0;
          end
        end
        PH_LAUNCHED: begin
          vel_d = vel_new;
          if (f_elapsed >= TIME_W'(minfl_q)) begin
            if (vel_nonpos) begin
              apend_d = 1'b1;
              aseen_d = aseen_eff;
              if (a_elapsed >= TIME_W'(aconf_q)) begin
                phase_d   = PH_APOGEE;
                ev_apogee = 1'b1;
                if (!chute_fired_q) begin
                  chute_level_d = 1'b1;
                  off_d         = s1_time_q + TIME_W'(pulse_q);
                  chute_fired_d = 1'b1;
                end
              end
            end else begin
              apend_d = 1'b0;
            end
          end
        end
        default: begin
          // apogee: only the pulse end, wrap-safe compare
          if (chute_fired_q && !off_diff[TIME_W-1]) chute_level_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      vel_q         <= '0;
      lpend_q       <= 1'b0;
      lseen_q       <= '0;
      apend_q       <= 1'b0;
      aseen_q       <= '0;
      fbegin_q      <= '0;
      chute_fired_q <= 1'b0;
      off_q         <= '0;
      chute_level_q <= 1'b0;
    end else if (s2_load) begin
      phase_q       <= phase_d;
      vel_q         <= vel_d;
      lpend_q       <= lpend_d;
      lseen_q       <= lseen_d;
      apend_q       <= apend_d;
      aseen_q       <= aseen_d;
      fbegin_q      <= fbegin_d;
      chute_fired_q <= chute_fired_d;
      off_q         <= off_d;
      chute_level_q <= chute_level_d;
    end
  end

  // ---------------- result register ----------------
  logic [PHASE_W-1:0]          out_phase_q;
  logic                        out_chute_q, out_launch_q, out_apogee_q;
  logic signed [EMA_W-1:0]     out_ema_q;
  logic signed [VEL_WIDTH-1:0] out_vel_q;

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      out_phase_q  <= phase_d;
      out_chute_q  <= chute_level_d;
      out_ema_q    <= s1_ema_q;
      out_vel_q    <= vel_d;
      out_launch_q <= ev_launch;
      out_apogee_q <= ev_apogee;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign phase_o          = out_phase_q;
  assign chute_out_o      = out_chute_q;
  assign filtered_accel_o = out_ema_q;
  assign velocity_sum_o   = out_vel_q;
  assign launch_event_o   = out_launch_q;
  assign apogee_event_o   = out_apogee_q;

  // ---------------- assertions ----------------
  a_launch_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && launch_event_o |-> phase_o == PH_LAUNCHED)
    else $error("launch beat not in launched phase");

  a_apogee_chute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && apogee_event_o |-> (phase_o == PH_APOGEE) && chute_out_o)
    else $error("apogee beat without apogee phase and chute drive");

  a_level_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chute_level_q |-> chute_fired_q)
    else $error("chute driven but never fired");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled while pipeline has room");

endmodule

`default_nettype wire
